@@ sv/linear_probe_hash_map_macros.svh @@
// assertion macros for the hash map checker
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

// property holds in the same cycle
`define LPHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the following cycle
`define LPHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lphm_pkg.sv @@
// shared types, codes and constants of the hash map
package lphm_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int MF_W      = 11;
  localparam logic [MF_W-1:0] MAX_FILL_RST = 11'd716;
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;

  // operation codes
  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  // slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // hash sequence steps
  localparam int HS_W = 4;
  localparam logic [HS_W-1:0] HS_XS30 = 4'd0;
  localparam logic [HS_W-1:0] HS_MLL1 = 4'd1;
  localparam logic [HS_W-1:0] HS_MLH1 = 4'd2;
  localparam logic [HS_W-1:0] HS_MHL1 = 4'd3;
  localparam logic [HS_W-1:0] HS_XS27 = 4'd4;
  localparam logic [HS_W-1:0] HS_MLL2 = 4'd5;
  localparam logic [HS_W-1:0] HS_MLH2 = 4'd6;
  localparam logic [HS_W-1:0] HS_MHL2 = 4'd7;
  localparam logic [HS_W-1:0] HS_XS31 = 4'd8;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  // controller to datapath commands
  typedef struct packed {
    logic            load;
    logic            hash;
    logic [HS_W-1:0] hstep;
    logic            fetch;
    logic            probe;
    logic            clr;
    logic            commit;
  } lphm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic probe_end;
    logic clr_last;
  } lphm_sts_t;

endpackage

@@ sv/linear_probe_hash_map.sv @@
// top level of the linear-probing hash map
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+------------------------
//  request  | in_mode, in_key, in_new_value                | start high, busy low
//  result   | out_status, out_read_value, out_live_entries | out_valid, one cycle
//  config   | cfg_max_fill                                 | cfg_valid & cfg_ready
//
// put, get and remove run the hash sequence on the mixer's shared 32x32 multiplier, then
// one home fetch, then probe 1 to SLOTS slots, one slot a cycle off the slot memories'
// single port, then one commit.
// clear, and reset, sweep the mark memory one slot a cycle with busy high.
// a new request may start in the cycle out_valid is shown; results cannot be stalled.
module linear_probe_hash_map import lphm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [KEY_W-1:0]           in_key,
  input  logic [VAL_W-1:0]           in_new_value,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [VAL_W-1:0]           out_read_value,
  output logic [$clog2(SLOTS):0]     out_live_entries,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [MF_W-1:0]            cfg_max_fill
);

  lphm_cmd_t       cmd;
  lphm_sts_t       sts;
  logic [MF_W-1:0] max_fill_r;

  // fill limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fill_r <= MAX_FILL_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_fill_r <= cfg_max_fill;
    end
  end

  assign cfg_ready = 1'b1;

  lphm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  lphm_dp #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_key(in_key), .in_new_value(in_new_value),
    .max_fill(max_fill_r),
    .out_valid(out_valid), .out_status(out_status),
    .out_read_value(out_read_value), .out_live_entries(out_live_entries)
  );

endmodule

@@ sv/lphm_ram.sv @@
// generic single-port ram with registered read
module lphm_ram #(
  parameter int W = 64,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lphm_ctrl.sv @@
// controller state machine of the hash map
module lphm_ctrl import lphm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [1:0] in_mode,
  input  lphm_sts_t sts,
  output lphm_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_HASH   = 6'b000100,
    S_FETCH  = 6'b001000,
    S_PROBE  = 6'b010000,
    S_COMMIT = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [HS_W-1:0] hstep_r, hstep_nxt;
  logic            rep_r, rep_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    hstep_nxt = hstep_r;
    rep_nxt   = rep_r;
    cmd       = '0;
    cmd.hstep = hstep_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = rep_r ? S_COMMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          hstep_nxt = HS_XS30;
          if (in_mode == MODE_CLEAR) begin
            state_nxt = S_CLEAR;
            rep_nxt   = 1'b1;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        hstep_nxt = hstep_r + 1'b1;
        if (hstep_r == HS_XS31) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_end) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        rep_nxt    = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers, reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      hstep_r <= HS_XS30;
      rep_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hstep_r <= hstep_nxt;
      rep_r   <= rep_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ sv/lphm_dp.sv @@
// datapath: hash unit, slot memories, probe tracking and result registers
module lphm_dp import lphm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IW    = $clog2(SLOTS),
  parameter int CNT_W = IW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lphm_cmd_t        cmd,
  output lphm_sts_t        sts,
  input  logic [1:0]       in_mode,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_new_value,
  input  logic [MF_W-1:0]  max_fill,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [VAL_W-1:0] out_read_value,
  output logic [CNT_W-1:0] out_live_entries
);

  localparam int CMP_W = (CNT_W > MF_W) ? CNT_W : MF_W;

  logic [1:0]       mode_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [63:0]      v_r, acc_r;
  logic [IW-1:0]    pos_r, n_r, at_r, tomb_r, clr_r;
  logic             hit_r, hole_vld_r, tomb_vld_r;
  logic [VAL_W-1:0] rdata_r;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic             out_valid_r;
  logic [2:0]       out_status_r, status_nxt;
  logic [VAL_W-1:0] out_rd_r, rd_nxt;

  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod, mix_c, fin;
  logic [1:0]       mark_rd, mark_wd;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] data_rd;
  logic             key_we, data_we, mark_we;
  logic [IW-1:0]    ram_addr, wr_addr;
  logic             is_empty, is_hit, is_last, full;

  // shared 32x32 multiplier of the mixer
  always_comb begin
    mix_c = (cmd.hstep >= HS_XS27) ? MIX_C2 : MIX_C1;
    mul_a = v_r[31:0];
    mul_b = mix_c[31:0];
    unique case (cmd.hstep)
      HS_MLH1, HS_MLH2: mul_b = mix_c[63:32];
      HS_MHL1, HS_MHL2: mul_a = v_r[63:32];
      default: mul_a = v_r[31:0];
    endcase
  end

  assign prod = mul_a * mul_b;
  assign fin  = acc_r ^ (acc_r >> 31);

  // probe decode of the slot being examined
  assign is_empty = (mark_rd == MARK_EMPTY);
  assign is_hit   = (mark_rd == MARK_LIVE) && (key_rd == key_r);
  assign is_last  = (n_r == IW'(SLOTS - 1));
  assign sts.probe_end = is_empty || is_hit || is_last;
  assign sts.clr_last  = (clr_r == IW'(SLOTS - 1));

  assign full = (CMP_W'(live_r) >= CMP_W'(max_fill)) || (!tomb_vld_r && !hole_vld_r);

  // operation outcome at commit
  always_comb begin
    status_nxt = ST_CLEARED;
    rd_nxt     = '0;
    live_nxt   = live_r;
    key_we     = 1'b0;
    data_we    = 1'b0;
    mark_we    = 1'b0;
    mark_wd    = MARK_EMPTY;
    wr_addr    = at_r;
    unique case (mode_r)
      MODE_PUT: begin
        if (hit_r) begin
          data_we    = 1'b1;
          status_nxt = ST_UPDATED;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_addr    = tomb_vld_r ? tomb_r : at_r;
          key_we     = 1'b1;
          data_we    = 1'b1;
          mark_we    = 1'b1;
          mark_wd    = MARK_LIVE;
          live_nxt   = CNT_W'(live_r + 1'b1);
          status_nxt = ST_INSERTED;
        end
      end
      MODE_GET: begin
        status_nxt = hit_r ? ST_FOUND : ST_NOT_FOUND;
        rd_nxt     = hit_r ? rdata_r : '0;
      end
      MODE_REMOVE: begin
        if (hit_r) begin
          mark_we    = 1'b1;
          mark_wd    = MARK_TOMB;
          live_nxt   = (live_r != '0) ? CNT_W'(live_r - 1'b1) : live_r;
          status_nxt = ST_REMOVED;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      MODE_CLEAR: status_nxt = ST_CLEARED;
      default:    status_nxt = ST_CLEARED;
    endcase
  end

  // memory address: sweep, commit write, home fetch or next slot
  always_comb begin
    priority if (cmd.clr) begin
      ram_addr = clr_r;
    end else if (cmd.commit) begin
      ram_addr = wr_addr;
    end else if (cmd.fetch) begin
      ram_addr = pos_r;
    end else begin
      ram_addr = IW'(pos_r + 1'b1);
    end
  end

  lphm_ram #(.W(KEY_W), .D(SLOTS)) u_key_ram (
    .clk(clk), .we(cmd.commit && key_we), .addr(ram_addr),
    .wdata(key_r), .rdata(key_rd)
  );

  lphm_ram #(.W(VAL_W), .D(SLOTS)) u_data_ram (
    .clk(clk), .we(cmd.commit && data_we), .addr(ram_addr),
    .wdata(val_r), .rdata(data_rd)
  );

  lphm_ram #(.W(2), .D(SLOTS)) u_mark_ram (
    .clk(clk), .we(cmd.clr || (cmd.commit && mark_we)), .addr(ram_addr),
    .wdata(cmd.clr ? MARK_EMPTY : mark_wd), .rdata(mark_rd)
  );

  // request capture, mixer and probe payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      val_r  <= in_new_value;
      v_r    <= in_key;
    end
    if (cmd.hash) begin
      unique case (cmd.hstep)
        HS_XS30:          v_r   <= v_r ^ (v_r >> 30);
        HS_MLL1, HS_MLL2: acc_r <= prod;
        HS_MLH1, HS_MLH2,
        HS_MHL1, HS_MHL2: acc_r <= acc_r + {prod[31:0], 32'd0};
        HS_XS27:          v_r   <= acc_r ^ (acc_r >> 27);
        HS_XS31: begin
          pos_r <= fin[IW-1:0];
        end
        default:          v_r   <= v_r;
      endcase
    end
    if (cmd.probe) begin
      pos_r <= IW'(pos_r + 1'b1);
      if (!is_empty && (mark_rd != MARK_LIVE) && !tomb_vld_r) begin
        tomb_r <= pos_r;
      end
      if (is_hit || is_empty) begin
        at_r <= pos_r;
      end
      if (is_hit) begin
        rdata_r <= data_rd;
      end
    end
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_rd_r     <= rd_nxt;
    end
  end

  // probe flags, counters and live count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      clr_r       <= '0;
      hit_r       <= 1'b0;
      hole_vld_r  <= 1'b0;
      tomb_vld_r  <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.hash && (cmd.hstep == HS_XS31)) begin
        n_r        <= '0;
        hit_r      <= 1'b0;
        hole_vld_r <= 1'b0;
        tomb_vld_r <= 1'b0;
      end
      if (cmd.probe) begin
        n_r <= IW'(n_r + 1'b1);
        if (is_hit) begin
          hit_r <= 1'b1;
        end
        if (is_empty) begin
          hole_vld_r <= 1'b1;
        end
        if (!is_empty && (mark_rd != MARK_LIVE)) begin
          tomb_vld_r <= 1'b1;
        end
      end
      if (cmd.clr) begin
        clr_r  <= IW'(clr_r + 1'b1);
        live_r <= '0;
      end
      if (cmd.commit) begin
        live_r <= live_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_value   = out_rd_r;
  assign out_live_entries = live_r;

endmodule

@@ sv/lphm_checker.sv @@
// port-level checks of the hash map and their binding
`include "linear_probe_hash_map_macros.svh"

module lphm_checker import lphm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [2:0]             out_status,
  input logic [VAL_W-1:0]       out_read_value,
  input logic [$clog2(SLOTS):0] out_live_entries
);

  // an accepted request keeps the block busy
  `LPHM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")
  // one result per request, never two in a row
  `LPHM_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "back-to-back results")
  // only a found lookup returns data
  `LPHM_ASSERT_NOW(a_read_zero, clk, rst_n, out_valid && (out_status != ST_FOUND),
                   out_read_value == '0, "read value on non-found result")
  // a cleared table is empty
  `LPHM_ASSERT_NOW(a_clear_empty, clk, rst_n, out_valid && (out_status == ST_CLEARED),
                   out_live_entries == '0, "live entries after clear")

endmodule

bind linear_probe_hash_map lphm_checker #(.SLOTS(SLOTS)) u_lphm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_read_value(out_read_value),
  .out_live_entries(out_live_entries)
);

@@ tb/linear_probe_hash_map_test.sv @@
// testbench of the linear-probing hash map: requests checked against a predictor
`timescale 1ns / 1ps

module linear_probe_hash_map_test import lphm_pkg::*; ();

  localparam int TABLE_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 6000000;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_mode;
  logic [KEY_W-1:0]       in_key;
  logic [VAL_W-1:0]       in_new_value;
  logic                   out_valid;
  logic [2:0]             out_status;
  logic [VAL_W-1:0]       out_read_value;
  logic [10:0]            out_live_entries;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [MF_W-1:0]        cfg_max_fill;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] read_value;
    logic [10:0]      live_entries;
  } map_result_t;

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_key [TABLE_SLOTS];
  logic [VAL_W-1:0] shadow_data [TABLE_SLOTS];
  logic [1:0]       shadow_mark [TABLE_SLOTS];
  int               shadow_live;
  int               shadow_tombs;
  int               shadow_fill;

  map_result_t pending_results[$];
  logic [KEY_W-1:0] used_keys[$];
  int  error_count;
  int  result_count;
  int  request_count;
  int  status_seen [8];
  longint cycle_count;
  bit  idling_on;

  linear_probe_hash_map dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_key(in_key), .in_new_value(in_new_value),
    .out_valid(out_valid), .out_status(out_status), .out_read_value(out_read_value),
    .out_live_entries(out_live_entries),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_max_fill(cfg_max_fill)
  );

  // clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("linear_probe_hash_map_test NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] splitmix_finalise(logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * 64'hbf58476d1ce4e5b9;
    v = v ^ (v >> 27);
    v = v * 64'h94d049bb133111eb;
    v = v ^ (v >> 31);
    return v;
  endfunction

  // predicted result of one request, updating the shadow table
  function automatic map_result_t predict_map_op(logic [1:0] mode, logic [63:0] key,
                                                 logic [63:0] val);
    map_result_t r;
    int pos, tomb, hole, at;
    r.read_value = '0;
    tomb = -1; hole = -1; at = -1;
    if (mode == MODE_CLEAR) begin
      foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
      shadow_live = 0;
      shadow_tombs = 0;
      r.status = ST_CLEARED;
    end else begin
      pos = int'(splitmix_finalise(key) & (TABLE_SLOTS - 1));
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (shadow_mark[pos] == MARK_EMPTY) begin
          hole = pos;
          break;
        end
        if (shadow_mark[pos] == MARK_LIVE) begin
          if (shadow_key[pos] == key) begin
            at = pos;
            break;
          end
        end else if (tomb < 0) begin
          tomb = pos;
        end
        pos = (pos + 1) & (TABLE_SLOTS - 1);
      end
      if (mode == MODE_PUT) begin
        if (at >= 0) begin
          shadow_data[at] = val;
          r.status = ST_UPDATED;
        end else if (shadow_live >= shadow_fill || (tomb < 0 && hole < 0)) begin
          r.status = ST_FULL;
        end else begin
          if (tomb >= 0) begin
            pos = tomb;
            if (shadow_tombs > 0) shadow_tombs--;
          end else begin
            pos = hole;
          end
          shadow_key[pos] = key;
          shadow_data[pos] = val;
          shadow_mark[pos] = MARK_LIVE;
          shadow_live++;
          r.status = ST_INSERTED;
        end
      end else if (mode == MODE_GET) begin
        if (at >= 0) begin
          r.read_value = shadow_data[at];
          r.status = ST_FOUND;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end else begin
        if (at >= 0) begin
          shadow_mark[at] = MARK_TOMB;
          if (shadow_live > 0) shadow_live--;
          shadow_tombs++;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    end
    r.live_entries = 11'(shadow_live);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(out_status), 64'h0);
      end else begin
        want = pending_results.pop_front();
        result_count++;
        status_seen[out_status]++;
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
        if (out_live_entries !== want.live_entries)
          report_mismatch("live_entries", 64'(out_live_entries), 64'(want.live_entries));
      end
    end
  end

  // random idle burst with start low, only while idling is on
  task automatic idle_gap();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // send one request and queue its expected result; start stays high for the next one
  task automatic send_request(logic [1:0] mode, logic [63:0] key, logic [63:0] val);
    idle_gap();
    start <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    in_new_value <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_map_op(mode, key, val));
    request_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TABLE_SLOTS + 40) @(negedge clk);
  endtask

  // max_fill written only while idle
  task automatic write_max_fill(logic [MF_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_max_fill <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_fill = int'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // key from a small pool so that hits, updates and removes are common
  function automatic logic [63:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 2) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    pick_key = random_word();
    used_keys.push_back(pick_key);
  endfunction

  task automatic test_directed_edges();
    send_request(MODE_GET, 64'h0, 64'h0);
    send_request(MODE_PUT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(MODE_GET, 64'h0, 64'h0);
    send_request(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234);
    send_request(MODE_PUT, 64'h0, 64'hA5A5_5A5A_A5A5_5A5A);
    send_request(MODE_GET, 64'h0, 64'h0);
    send_request(MODE_REMOVE, 64'h0, 64'h0);
    send_request(MODE_REMOVE, 64'h0, 64'h0);
    send_request(MODE_GET, 64'h0, 64'h0);
    // reinsert lands in the tombstone
    send_request(MODE_PUT, 64'h0, 64'h5555_AAAA_5555_AAAA);
    send_request(MODE_REMOVE, 64'h1, 64'h0);
    send_request(MODE_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
  endtask

  // tiny fill limit: full refusal, update at the limit, zero limit
  task automatic test_fill_limit();
    write_max_fill(11'd2);
    send_request(MODE_PUT, 64'h11, 64'h1);
    send_request(MODE_PUT, 64'h22, 64'h2);
    send_request(MODE_PUT, 64'h33, 64'h3);
    send_request(MODE_PUT, 64'h22, 64'h7);
    send_request(MODE_GET, 64'h22, 64'h0);
    write_max_fill(11'd0);
    send_request(MODE_PUT, 64'h44, 64'h4);
    send_request(MODE_PUT, 64'h11, 64'h9);
    send_request(MODE_CLEAR, 64'h0, 64'h0);
    write_max_fill(11'h7FF);
  endtask

  // fill every slot so that bounded walks and table-full refusals occur
  task automatic test_full_table();
    logic [63:0] k;
    idling_on = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) send_request(MODE_PUT, 64'(i) << 20, random_word());
    send_request(MODE_PUT, 64'hDEAD_BEEF_0000_0001, 64'h1);
    send_request(MODE_GET, 64'hDEAD_BEEF_0000_0001, 64'h0);
    send_request(MODE_REMOVE, 64'h5 << 20, 64'h0);
    send_request(MODE_GET, 64'hDEAD_BEEF_0000_0002, 64'h0);
    send_request(MODE_PUT, 64'hDEAD_BEEF_0000_0003, 64'h3);
    k = 64'h7 << 20;
    send_request(MODE_GET, k, 64'h0);
    send_request(MODE_CLEAR, 64'h0, 64'h0);
    idling_on = 1'b1;
  endtask

  // random operations in phases of different fill limits
  task automatic test_random_mix(int count, logic [MF_W-1:0] fill);
    int sel;
    logic [1:0] mode;
    write_max_fill(fill);
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      mode = sel < 45 ? MODE_PUT : sel < 75 ? MODE_GET : sel < 98 ? MODE_REMOVE : MODE_CLEAR;
      send_request(mode, pick_key(), random_word());
      if (i == count / 2 && fill == 11'd716) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_GET;
    in_key = '0;
    in_new_value = '0;
    cfg_valid = 1'b0;
    cfg_max_fill = MAX_FILL_RST;
    cycle_count = 0;
    error_count = 0;
    result_count = 0;
    request_count = 0;
    idling_on = 1'b1;
    shadow_live = 0;
    shadow_tombs = 0;
    shadow_fill = int'(MAX_FILL_RST);
    foreach (shadow_mark[i]) begin
      shadow_mark[i] = MARK_EMPTY;
      shadow_key[i] = '0;
      shadow_data[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_fill_limit();
    test_full_table();
    test_random_mix(30, 11'd716);
    test_random_mix(15, 11'd40);
    test_random_mix(15, 11'd1);
    idling_on = 1'b0;
    test_random_mix(30, 11'd1024);

    wait_drained();
    $display("%0d requests, %0d results; statuses ins %0d upd %0d fnd %0d nf %0d",
             request_count, result_count, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3]);
    $display("rem %0d full %0d clr %0d; fill limits 0 to 2047 applied, full table walked",
             status_seen[4], status_seen[5], status_seen[6]);
    if (error_count == 0 && pending_results.size() == 0)
      $display("linear_probe_hash_map_test OK");
    else
      $display("linear_probe_hash_map_test NOT OK");
    $finish;
  end

endmodule
